// ===== rtl/clt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clt_pkg
// Types, constants and helpers shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam int MAX_MESSAGE_BYTES = 4096;
    // Position counter must hold MAX_MESSAGE_BYTES itself (saturation value).
    localparam int POS_W   = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int FIELD_W = 13;
    localparam int RES_MAX = 3;
    localparam int CNT_W   = 2;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_P     = 8'h50;

    typedef enum logic [2:0] {
        KIND_END  = 3'd0,
        KIND_NUM  = 3'd1,
        KIND_STR  = 3'd2,
        KIND_ID   = 3'd3,
        KIND_HELO = 3'd4,
        KIND_CAP  = 3'd5,
        KIND_ERR  = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_NUM  = 2'd1,
        PH_STR  = 2'd2,
        PH_ID   = 2'd3
    } t_phase;

    typedef struct packed {
        t_kind              kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
    } t_token;

    // Tokens produced by one input beat, packed from slot 0 upward.
    typedef struct packed {
        logic [CNT_W-1:0]        count;
        t_token [RES_MAX-1:0]    tok;
    } t_group;

    // Fit a position value into an output field (zero-extend or truncate).
    function automatic logic [FIELD_W-1:0] to_field(input logic [POS_W-1:0] v);
        logic [POS_W+FIELD_W-1:0] w;
        w = {{FIELD_W{1'b0}}, v};
        return w[FIELD_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/command_line_tokenizer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// command_line_tokenizer_unit
// Streaming tokenizer for one protocol message line, one byte per beat.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle, unless stalled by the result register, and
// reports number, string, identifier and HELO/CAP keyword tokens with start
// offset and length, an error token for a string still open at the end, then
// an end token when the message ends. A byte beat sits in an input register,
// is classified against the scanner state, and its tokens (zero to three) move
// into a result register in the same cycle. A beat that yields k tokens holds
// off the next group until its last token is taken, as the result register
// hands out one token per beat; tokens pass the input, then the result register.
module command_line_tokenizer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    input  wire logic        i_end_only,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_token_kind,
    output logic [12:0]      o_token_start,
    output logic [12:0]      o_token_length,
    output logic             o_last_result
);
    import clt_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_data;
    logic       r_last;
    logic       r_end;
    logic       load_ok;
    logic       fire;
    t_group     group;
    t_token     token;

    assign fire    = r_in_valid && load_ok;
    assign o_ready = !r_in_valid || load_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data_byte;
            r_last <= i_last_byte;
            r_end  <= i_end_only;
        end
    end

    clt_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_data_byte (r_data),
        .i_last_byte (r_last),
        .i_end_only  (r_end),
        .o_group     (group)
    );

    clt_result_buf u_result_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (fire),
        .i_group       (group),
        .o_load_ok     (load_ok),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_token       (token),
        .o_last_result (o_last_result)
    );

    assign o_token_kind   = token.kind;
    assign o_token_start  = token.start;
    assign o_token_length = token.length;

endmodule
`default_nettype wire

// ===== rtl/clt_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clt_scan
// Scanner state and per-byte classification; builds the token group of a beat.
// ----------------------------------------------------------------------------
module clt_scan (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_last_byte,
    input  wire logic          i_end_only,
    output clt_pkg::t_group    o_group
);
    import clt_pkg::*;

    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_begin, n_begin;
    logic             r_helo, n_helo;
    logic             r_cap, n_cap;

    function automatic t_kind id_kind(input logic helo, input logic cap,
                                      input logic [POS_W-1:0] len);
        t_kind k;
        k = KIND_ID;
        if (helo && len == POS_W'(4)) begin
            k = KIND_HELO;
        end else if (cap && len == POS_W'(3)) begin
            k = KIND_CAP;
        end
        return k;
    endfunction

    always_comb begin
        logic [7:0]       c;
        logic [POS_W-1:0] nxt;
        logic [POS_W-1:0] end_pos;
        logic [POS_W-1:0] k;
        logic             digit;
        logic             sep;
        logic             mid_v;
        t_token           mid;
        logic             close_v;
        t_token           close_t;
        logic             fin;
        t_token           end_t;
        logic [CNT_W-1:0] n;

        c       = i_data_byte;
        digit   = (c inside {[CH_0:CH_9]});
        sep     = (c == CH_SPACE) || (c == CH_TAB);
        nxt     = (r_pos < POS_W'(MAX_MESSAGE_BYTES)) ? r_pos + POS_W'(1)
                                                      : POS_W'(MAX_MESSAGE_BYTES);
        k       = r_pos - r_begin;
        n_phase = r_phase;
        n_pos   = r_pos;
        n_begin = r_begin;
        n_helo  = r_helo;
        n_cap   = r_cap;
        mid_v   = 1'b0;
        mid     = '{kind: KIND_NUM, start: to_field(r_begin), length: to_field(k)};
        close_v = 1'b0;
        close_t = mid;
        end_pos = r_pos;
        fin     = i_end_only || i_last_byte;

        if (!i_end_only) begin
            // A number ends before the first non-digit, which is then rescanned.
            if (r_phase == PH_NUM && !digit) begin
                mid_v   = 1'b1;
                n_phase = PH_IDLE;
            end
            case (n_phase)
                PH_IDLE: begin
                    if (!sep) begin
                        n_begin = r_pos;
                        if (digit) begin
                            n_phase = PH_NUM;
                        end else if (c == CH_QUOTE) begin
                            n_phase = PH_STR;
                        end else begin
                            n_phase = PH_ID;
                            n_helo  = (c == CH_H);
                            n_cap   = (c == CH_C);
                        end
                    end
                end
                PH_STR: begin
                    if (c == CH_QUOTE) begin
                        mid_v   = 1'b1;
                        mid     = '{kind: KIND_STR, start: to_field(r_begin),
                                    length: to_field(nxt - r_begin)};
                        n_phase = PH_IDLE;
                    end
                end
                PH_ID: begin
                    if (sep) begin
                        mid_v   = 1'b1;
                        mid     = '{kind: id_kind(r_helo, r_cap, k),
                                    start: to_field(r_begin), length: to_field(k)};
                        n_phase = PH_IDLE;
                    end else begin
                        n_helo = r_helo && ((k == POS_W'(1) && c == CH_E) ||
                                            (k == POS_W'(2) && c == CH_L) ||
                                            (k == POS_W'(3) && c == CH_O));
                        n_cap  = r_cap && ((k == POS_W'(1) && c == CH_A) ||
                                           (k == POS_W'(2) && c == CH_P));
                    end
                end
                default: begin
                end
            endcase
            n_pos   = nxt;
            end_pos = nxt;
        end

        // Close whatever is still open at the message end.
        close_t = '{kind: KIND_NUM, start: to_field(n_begin),
                    length: to_field(end_pos - n_begin)};
        case (n_phase)
            PH_NUM: close_v = fin;
            PH_STR: begin
                close_v      = fin;
                close_t.kind = KIND_ERR;
            end
            PH_ID: begin
                close_v      = fin;
                close_t.kind = id_kind(n_helo, n_cap, end_pos - n_begin);
            end
            default: close_v = 1'b0;
        endcase
        end_t = '{kind: KIND_END, start: to_field(end_pos), length: '0};

        if (fin) begin
            n_phase = PH_IDLE;
            n_pos   = '0;
            n_begin = '0;
            n_helo  = 1'b0;
            n_cap   = 1'b0;
        end

        o_group.tok = {end_t, close_t, mid};
        n = '0;
        if (mid_v) begin
            o_group.tok[n] = mid;
            n = n + CNT_W'(1);
        end
        if (close_v) begin
            o_group.tok[n] = close_t;
            n = n + CNT_W'(1);
        end
        if (fin) begin
            o_group.tok[n] = end_t;
            n = n + CNT_W'(1);
        end
        o_group.count = n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_begin <= '0;
            r_helo  <= 1'b0;
            r_cap   <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_begin <= n_begin;
            r_helo  <= n_helo;
            r_cap   <= n_cap;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/clt_result_buf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clt_result_buf
// Result register: holds the token group of one beat and drains it in order.
// ----------------------------------------------------------------------------
module clt_result_buf (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  clt_pkg::t_group    i_group,
    output logic               o_load_ok,
    output logic               o_valid,
    input  wire logic          i_ready,
    output clt_pkg::t_token    o_token,
    output logic               o_last_result
);
    import clt_pkg::*;

    t_token [RES_MAX-1:0] r_tok;
    logic [CNT_W-1:0]     r_cnt;
    logic                 take;

    assign o_valid       = (r_cnt != '0);
    assign take          = o_valid && i_ready;
    assign o_token       = r_tok[0];
    assign o_last_result = (r_cnt == CNT_W'(1));
    // Accept a new group once the current one is gone or leaves this cycle.
    assign o_load_ok     = (r_cnt == '0) || (o_last_result && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_group.count;
        end else if (take) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tok <= i_group.tok;
        end else if (take) begin
            // advance to the next token of the group
            for (int i = 0; i < RES_MAX - 1; i++) begin
                r_tok[i] <= r_tok[i+1];
            end
        end
    end

endmodule
`default_nettype wire
